>>> design/cq_pkg.sv
package cq_pkg;

	localparam int QSEL_W = 3;
	localparam int QSEL_N = 1 << QSEL_W;
	localparam int COUNT_W = 11;

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOBLK = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [QSEL_W-1:0] queue_select;
		logic [7:0]        data_byte;
	} op_t;

	typedef struct packed {
		logic [7:0]         read_byte;
		logic [1:0]         status;
		logic [COUNT_W-1:0] queue_count;
	} res_t;

endpackage

>>> design/cq_op_if.sv
interface cq_op_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [cq_pkg::QSEL_W-1:0] queue_select;
	logic [7:0]                data_byte;

	modport source (output valid, output operation, output queue_select, output data_byte,
		input ready);
	modport sink (input valid, input operation, input queue_select, input data_byte,
		output ready);
endinterface

>>> design/cq_res_if.sv
interface cq_res_if;
	logic                       valid;
	logic                       ready;
	logic [7:0]                 read_byte;
	logic [1:0]                 status;
	logic [cq_pkg::COUNT_W-1:0] queue_count;

	modport source (output valid, output read_byte, output status, output queue_count,
		input ready);
	modport sink (input valid, input read_byte, input status, input queue_count,
		output ready);
endinterface

>>> design/cq_ram.sv
module cq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write-through: a read of the address written on the same edge sees the new data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
		end
	end

endmodule

>>> design/cq_ctrl.sv
module cq_ctrl #(
	parameter int NUM_BLOCKS = 64,
	parameter int BLOCK_BYTES = 16,
	parameter int NUM_QUEUES = 8,
	localparam int LW = $clog2(NUM_BLOCKS),
	localparam int BW = $clog2(NUM_BLOCKS + 1),
	localparam int OW = $clog2(BLOCK_BYTES),
	localparam int AW = $clog2(NUM_BLOCKS * BLOCK_BYTES),
	localparam int CW = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  cq_pkg::op_t        item_s1,
	input  cq_pkg::op_t        item_in,
	input  logic [BW-1:0]      lk_rdata,
	input  logic [7:0]         byte_rdata,
	output cq_pkg::res_t       res,
	output logic               byte_we,
	output logic [AW-1:0]      byte_waddr,
	output logic [7:0]         byte_wdata,
	output logic [AW-1:0]      byte_raddr,
	output logic               lk_we,
	output logic [LW-1:0]      lk_waddr,
	output logic [BW-1:0]      lk_wdata,
	output logic [LW-1:0]      lk_raddr
);

	localparam int QN = (NUM_QUEUES < cq_pkg::QSEL_N) ? NUM_QUEUES : cq_pkg::QSEL_N;
	localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
	localparam logic [BW-1:0] NULL_BLK = BW'(NUM_BLOCKS);
	localparam logic [OW-1:0] OFF_LAST = OW'(BLOCK_BYTES - 1);

	logic [BW-1:0] head_blk_q [QN];
	logic [OW-1:0] head_off_q [QN];
	logic [BW-1:0] tail_blk_q [QN];
	logic [OW-1:0] tail_off_q [QN];
	logic [CW-1:0] cnt_q [QN];
	logic [BW-1:0] free_q;
	logic [BW-1:0] fresh_q;

	logic [BW-1:0] head_blk_d [QN];
	logic [OW-1:0] head_off_d [QN];
	logic [BW-1:0] tail_blk_d [QN];
	logic [OW-1:0] tail_off_d [QN];
	logic [CW-1:0] cnt_d [QN];
	logic [BW-1:0] free_d;
	logic [BW-1:0] fresh_d;

	logic           in_rng;
	logic [QIW-1:0] qi;
	logic [QIW-1:0] nqi;
	logic [BW-1:0]  la;
	logic [BW-1:0]  link_v;
	logic [BW-1:0]  lk_ra_full;

	function automatic logic [AW-1:0] pos_addr(logic [BW-1:0] b, logic [OW-1:0] o);
		return AW'(int'(b) * BLOCK_BYTES + int'(o));
	endfunction

	assign in_rng = int'(item_s1.queue_select) < NUM_QUEUES;
	assign qi = in_rng ? item_s1.queue_select[QIW-1:0] : '0;

	// blocks at or above fresh_q have been handed out at least once; below it the
	// pool still holds its reset chain, block i linking to block i-1
	assign la = (item_s1.operation == cq_pkg::OP_GET) ? head_blk_q[qi] : free_q;
	assign link_v = (la < fresh_q) ? ((la == '0) ? NULL_BLK : la - 1'b1) : lk_rdata;

	always_comb begin
		head_blk_d = head_blk_q;
		head_off_d = head_off_q;
		tail_blk_d = tail_blk_q;
		tail_off_d = tail_off_q;
		cnt_d = cnt_q;
		free_d = free_q;
		fresh_d = fresh_q;
		res = '0;
		byte_we = 1'b0;
		byte_waddr = '0;
		byte_wdata = item_s1.data_byte;
		lk_we = 1'b0;
		lk_waddr = '0;
		lk_wdata = free_q;
		if (commit) begin
			if (!in_rng) begin
				res.status = (item_s1.operation == cq_pkg::OP_GET) ?
					cq_pkg::ST_EMPTY : cq_pkg::ST_NOBLK;
			end else if (item_s1.operation == cq_pkg::OP_PUT) begin
				if (cnt_q[qi] == '0 || tail_off_q[qi] == OFF_LAST) begin
					if (free_q == NULL_BLK) begin
						res.status = cq_pkg::ST_NOBLK;
						res.queue_count = cq_pkg::COUNT_W'(cnt_q[qi]);
					end else begin
						free_d = link_v;
						if (free_q < fresh_q) begin
							fresh_d = free_q;
						end
						if (cnt_q[qi] == '0) begin
							head_blk_d[qi] = free_q;
							head_off_d[qi] = '0;
						end else begin
							lk_we = 1'b1;
							lk_waddr = tail_blk_q[qi][LW-1:0];
						end
						tail_blk_d[qi] = free_q;
						tail_off_d[qi] = '0;
						byte_we = 1'b1;
						byte_waddr = pos_addr(free_q, '0);
						cnt_d[qi] = cnt_q[qi] + 1'b1;
						res.status = cq_pkg::ST_OK;
						res.queue_count = cq_pkg::COUNT_W'(cnt_d[qi]);
					end
				end else begin
					tail_off_d[qi] = tail_off_q[qi] + 1'b1;
					byte_we = 1'b1;
					byte_waddr = pos_addr(tail_blk_q[qi], tail_off_d[qi]);
					cnt_d[qi] = cnt_q[qi] + 1'b1;
					res.status = cq_pkg::ST_OK;
					res.queue_count = cq_pkg::COUNT_W'(cnt_d[qi]);
				end
			end else begin
				if (cnt_q[qi] == '0) begin
					res.status = cq_pkg::ST_EMPTY;
				end else begin
					res.read_byte = byte_rdata;
					cnt_d[qi] = cnt_q[qi] - 1'b1;
					res.status = cq_pkg::ST_OK;
					res.queue_count = cq_pkg::COUNT_W'(cnt_d[qi]);
					if (cnt_d[qi] == '0 || head_off_q[qi] == OFF_LAST) begin
						// drained block goes back on the free list
						lk_we = 1'b1;
						lk_waddr = head_blk_q[qi][LW-1:0];
						free_d = head_blk_q[qi];
						if (cnt_d[qi] != '0) begin
							head_blk_d[qi] = link_v;
							head_off_d[qi] = '0;
						end
					end else begin
						head_off_d[qi] = head_off_q[qi] + 1'b1;
					end
				end
			end
		end
	end

	// reads for the incoming item see the state as it stands after this commit
	assign nqi = (int'(item_in.queue_select) < NUM_QUEUES) ?
		item_in.queue_select[QIW-1:0] : '0;
	assign byte_raddr = pos_addr(head_blk_d[nqi], head_off_d[nqi]);
	assign lk_ra_full = (item_in.operation == cq_pkg::OP_GET) ? head_blk_d[nqi] : free_d;
	assign lk_raddr = lk_ra_full[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QN; i++) begin
				head_blk_q[i] <= '0;
				head_off_q[i] <= '0;
				tail_blk_q[i] <= '0;
				tail_off_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			free_q <= BW'(NUM_BLOCKS - 1);
			fresh_q <= NULL_BLK;
		end else if (commit) begin
			head_blk_q <= head_blk_d;
			head_off_q <= head_off_d;
			tail_blk_q <= tail_blk_d;
			tail_off_q <= tail_off_d;
			cnt_q <= cnt_d;
			free_q <= free_d;
			fresh_q <= fresh_d;
		end
	end

endmodule

>>> design/block_chained_char_queues.sv
// A result is offered on rsp after its item passes the item_s1 and res_q registers.
// One item per cycle while rsp is not stalled, set by the update of the queue table
// at each commit with the block store and link memory read on the accepting edge.
// Reset (arst_n low, asynchronous): all queues empty, every block free; untouched
// blocks are tracked by a frontier register, so no clearing pass is needed.
module block_chained_char_queues #(
	parameter int NUM_BLOCKS = 64,
	parameter int BLOCK_BYTES = 16,
	parameter int NUM_QUEUES = 8
) (
	input logic       clk,
	input logic       arst_n,
	cq_op_if.sink     req,
	cq_res_if.source  rsp
);

	localparam int LW = $clog2(NUM_BLOCKS);
	localparam int BW = $clog2(NUM_BLOCKS + 1);
	localparam int AW = $clog2(NUM_BLOCKS * BLOCK_BYTES);

	logic         valid_s1;
	cq_pkg::op_t  item_s1;
	cq_pkg::op_t  item_in;
	logic         fire_s1;
	logic         accept;
	logic         out_valid_q;
	cq_pkg::res_t res_q;
	cq_pkg::res_t res;

	logic          byte_we;
	logic [AW-1:0] byte_waddr;
	logic [7:0]    byte_wdata;
	logic [AW-1:0] byte_raddr;
	logic [7:0]    byte_rdata;
	logic          lk_we;
	logic [LW-1:0] lk_waddr;
	logic [BW-1:0] lk_wdata;
	logic [LW-1:0] lk_raddr;
	logic [BW-1:0] lk_rdata;

	assign item_in = '{operation: req.operation, queue_select: req.queue_select,
		data_byte: req.data_byte};

	assign fire_s1 = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire_s1;
	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (fire_s1) begin
			res_q <= res;
		end
	end

	cq_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.BLOCK_BYTES(BLOCK_BYTES),
		.NUM_QUEUES(NUM_QUEUES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.commit(fire_s1),
		.item_s1(item_s1),
		.item_in(item_in),
		.lk_rdata(lk_rdata),
		.byte_rdata(byte_rdata),
		.res(res),
		.byte_we(byte_we),
		.byte_waddr(byte_waddr),
		.byte_wdata(byte_wdata),
		.byte_raddr(byte_raddr),
		.lk_we(lk_we),
		.lk_waddr(lk_waddr),
		.lk_wdata(lk_wdata),
		.lk_raddr(lk_raddr)
	);

	cq_ram #(
		.DEPTH(NUM_BLOCKS * BLOCK_BYTES),
		.WIDTH(8)
	) u_bytes (
		.clk(clk),
		.we(byte_we),
		.waddr(byte_waddr),
		.wdata(byte_wdata),
		.re(accept),
		.raddr(byte_raddr),
		.rdata(byte_rdata)
	);

	cq_ram #(
		.DEPTH(NUM_BLOCKS),
		.WIDTH(BW)
	) u_links (
		.clk(clk),
		.we(lk_we),
		.waddr(lk_waddr),
		.wdata(lk_wdata),
		.re(accept),
		.raddr(lk_raddr),
		.rdata(lk_rdata)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.read_byte = res_q.read_byte;
	assign rsp.status = res_q.status;
	assign rsp.queue_count = res_q.queue_count;

endmodule

>>> design/cq_chk.sv
module cq_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [7:0]                 read_byte,
	input logic [1:0]                 status,
	input logic [cq_pkg::COUNT_W-1:0] queue_count
);

	// back-pressure on req only while a finished item is held on rsp
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("req stalled without a held item on rsp");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cq_pkg::ST_EMPTY |-> queue_count == '0)
		else $error("empty status with non-zero count");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_byte != '0 |-> status == cq_pkg::ST_OK)
		else $error("byte returned on a failed operation");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(queue_count) && $stable(status))
		else $error("rsp item changed while stalled");

endmodule

bind block_chained_char_queues cq_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.read_byte(rsp.read_byte),
	.status(rsp.status),
	.queue_count(rsp.queue_count)
);

>>> bench/tb_block_chained_char_queues.sv
`timescale 1ns / 100ps

module tb_block_chained_char_queues;

	localparam int NBLK = 64;
	localparam int BLEN = 16;
	localparam int NQ = 8;
	localparam int QW = cq_pkg::QSEL_W;
	localparam int LINK_W = $clog2(NBLK + 1);
	localparam int POS_W = $clog2(NBLK * BLEN);
	localparam logic [LINK_W-1:0] NO_BLK = LINK_W'(NBLK);
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_AT = 600;
	localparam int HOLD_CYCLES = 400;

	class cq_tracker;
		logic [7:0]                 store [NBLK*BLEN];
		logic [LINK_W-1:0]          link [NBLK];
		logic [LINK_W-1:0]          free_head;
		logic [POS_W-1:0]           hd [NQ];
		logic [POS_W-1:0]           tl [NQ];
		logic [cq_pkg::COUNT_W-1:0] cnt [NQ];
		cq_pkg::res_t               pending [$];
		int                         n_ops, n_checked, n_errors;
		int                         n_put_ok, n_get_ok, n_empty, n_refused, deepest;

		function new();
			for (int i = 0; i < NBLK; i++)
				link[i] = (i == 0) ? NO_BLK : LINK_W'(i - 1);
			free_head = LINK_W'(NBLK - 1);
			for (int i = 0; i < NQ; i++) begin
				hd[i] = '0;
				tl[i] = '0;
				cnt[i] = '0;
			end
		endfunction

		function logic [LINK_W-1:0] take_blk();
			logic [LINK_W-1:0] b;
			b = free_head;
			if (b >= NO_BLK)
				return NO_BLK;
			free_head = link[b];
			if (free_head > NO_BLK)
				free_head = NO_BLK;
			link[b] = NO_BLK;
			return b;
		endfunction

		function void give_blk(logic [LINK_W-1:0] b);
			if (b < NO_BLK) begin
				link[b] = free_head;
				free_head = b;
			end
		endfunction

		// works out the result of one operation and queues it
		function void note_op(cq_pkg::op_t it);
			cq_pkg::res_t r;
			int q, pos;
			logic [LINK_W-1:0] b, cur, nxt;
			bit ok;
			r = '0;
			q = it.queue_select;
			ok = 1;
			pos = 0;
			n_ops++;
			if (q >= NQ) begin
				r.status = (it.operation == cq_pkg::OP_GET) ? cq_pkg::ST_EMPTY : cq_pkg::ST_NOBLK;
			end else if (it.operation == cq_pkg::OP_PUT) begin
				if (cnt[q] == 0) begin
					b = take_blk();
					if (b == NO_BLK) ok = 0;
					else begin
						pos = b * BLEN;
						hd[q] = POS_W'(pos);
					end
				end else if (tl[q] % BLEN == BLEN - 1) begin
					cur = LINK_W'(tl[q] / BLEN);
					b = take_blk();
					if (b == NO_BLK) ok = 0;
					else begin
						link[cur] = b;
						pos = b * BLEN;
					end
				end else begin
					pos = tl[q] + 1;
				end
				if (ok) begin
					store[pos] = it.data_byte;
					tl[q] = POS_W'(pos);
					cnt[q]++;
					n_put_ok++;
				end else begin
					r.status = cq_pkg::ST_NOBLK;
					n_refused++;
				end
				r.queue_count = cnt[q];
				if (cnt[q] > deepest) deepest = cnt[q];
			end else begin
				if (cnt[q] == 0) begin
					r.status = cq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					pos = hd[q];
					b = LINK_W'(pos / BLEN);
					r.read_byte = store[pos];
					cnt[q]--;
					n_get_ok++;
					if (cnt[q] == 0) begin
						give_blk(b);
						hd[q] = '0;
						tl[q] = '0;
					end else if (pos % BLEN == BLEN - 1) begin
						nxt = link[b];
						give_blk(b);
						if (nxt >= NO_BLK) begin
							cnt[q] = '0;
							hd[q] = '0;
							tl[q] = '0;
						end else begin
							hd[q] = POS_W'(nxt * BLEN);
						end
					end else begin
						hd[q] = POS_W'(pos + 1);
					end
					r.queue_count = cnt[q];
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(cq_pkg::res_t got);
			cq_pkg::res_t want;
			n_checked++;
			if (pending.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: unexpected result byte=%0d status=%0d count=%0d",
						got.read_byte, got.status, got.queue_count);
				return;
			end
			want = pending.pop_front();
			if (got.read_byte !== want.read_byte || got.status !== want.status ||
				got.queue_count !== want.queue_count) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: result %0d: byte %0d/%0d status %0d/%0d count %0d/%0d (exp/got)",
						n_checked, want.read_byte, got.read_byte, want.status, got.status,
						want.queue_count, got.queue_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	cq_op_if  req ();
	cq_res_if rsp ();
	cq_tracker sb = new();
	int n_sent;
	int burst_left;
	int cycles;
	bit held;

	block_chained_char_queues #(
		.NUM_BLOCKS(NBLK),
		.BLOCK_BYTES(BLEN),
		.NUM_QUEUES(NQ)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end else if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_op(cq_pkg::op_t'{req.operation, req.queue_select, req.data_byte});
			if (rsp.valid && rsp.ready)
				sb.check_result(cq_pkg::res_t'{rsp.read_byte, rsp.status, rsp.queue_count});
		end
	end

	// receiver: shifting stall patterns, one long hold-off to back the block up
	initial begin
		int mode, len, k;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		k = 0;
		forever begin
			if (!held && sb.n_ops >= HOLD_AT) begin
				held = 1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 80);
			repeat (len) begin
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= (k % 4) != 3;
					default: rsp.ready <= (k % 7) < 2;
				endcase
				k++;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic op, input logic [QW-1:0] q, input logic [7:0] d);
		int gap;
		req.valid <= 1'b1;
		req.operation <= op;
		req.queue_select <= q;
		req.data_byte <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic run_mix(input int n, input int put_pct, input int qmax);
		logic op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 99) < put_pct) ? cq_pkg::OP_PUT : cq_pkg::OP_GET;
			send_item(op, QW'($urandom_range(0, qmax)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = cq_pkg::OP_PUT;
		req.queue_select = '0;
		req.data_byte = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 40);

		// directed: empty gets, field extremes, fifo order, drain to empty
		send_item(cq_pkg::OP_GET, 3'd0, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd7, 8'hFF);
		send_item(cq_pkg::OP_PUT, 3'd0, 8'h00);
		send_item(cq_pkg::OP_PUT, 3'd7, 8'hFF);
		send_item(cq_pkg::OP_PUT, 3'd0, 8'hFF);
		send_item(cq_pkg::OP_PUT, 3'd7, 8'h00);
		send_item(cq_pkg::OP_PUT, 3'd0, 8'hA5);
		send_item(cq_pkg::OP_GET, 3'd0, 8'hFF);
		send_item(cq_pkg::OP_GET, 3'd7, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd0, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd0, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd0, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd7, 8'h00);
		send_item(cq_pkg::OP_GET, 3'd7, 8'h00);
		send_item(cq_pkg::OP_PUT, 3'd5, 8'h5A);
		send_item(cq_pkg::OP_PUT, 3'd2, 8'h81);
		send_item(cq_pkg::OP_GET, 3'd5, 8'h00);

		run_mix(200, 50, NQ - 1);
		// fill the pool until puts are refused, then shift the mix towards gets
		run_mix(1100, 99, 3);
		run_mix(100, 60, NQ - 1);
		run_mix(100, 15, NQ - 1);

		req.valid <= 1'b0;
		while (sb.n_ops != n_sent || sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.pending.size() != 0)
			sb.n_errors++;
		$display("%0d items, %0d results: %0d puts stored, %0d refused, %0d bytes read",
			sb.n_ops, sb.n_checked, sb.n_put_ok, sb.n_refused, sb.n_get_ok);
		$display("%0d gets on empty queues, deepest queue %0d bytes, %0d mismatches",
			sb.n_empty, sb.deepest, sb.n_errors);
		if (sb.n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
design/cq_pkg.sv
design/cq_op_if.sv
design/cq_res_if.sv
design/cq_ram.sv
design/cq_ctrl.sv
design/block_chained_char_queues.sv
design/cq_chk.sv
bench/tb_block_chained_char_queues.sv
